// ===== src/assert_macros.svh =====
// Assertion macros used by the top level of the priority message queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define PMQ_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("pmq assertion failed");

// Same-cycle implication.
`define PMQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pmq implication failed");

// Next-cycle implication.
`define PMQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pmq next-cycle implication failed");

`endif

// ===== src/pmq_pkg.sv =====
// Types and constants of the priority message queue.
`timescale 1ns / 1ps

package pmq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int PRIO_W    = 15;
    localparam int PAYLOAD_W = 32;
    localparam int LEN_W     = 16;
    localparam int MAXMSG_W  = 5;
    localparam int QCOUNT_W  = 5;

    // opcodes
    localparam logic OP_SEND = 1'b0;
    localparam logic OP_RECV = 1'b1;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_MAX_MESSAGES = 2'd0;
    localparam logic [1:0] REG_MAX_MSG_SIZE = 2'd1;
    localparam logic [1:0] REG_NONBLOCKING  = 2'd2;

    localparam logic [MAXMSG_W-1:0] MAX_MESSAGES_RST = 5'd16;
    localparam logic [LEN_W-1:0]    MAX_MSG_SIZE_RST = 16'd8192;
    localparam logic                NONBLOCKING_RST  = 1'b0;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SIZE  = 2'd1,
        ST_BLOCK = 2'd2,
        ST_AGAIN = 2'd3
    } status_t;

    typedef struct packed {
        logic [PRIO_W-1:0]    prio;
        logic [PAYLOAD_W-1:0] payload;
        logic [LEN_W-1:0]     length;
    } entry_t;

    // broadcast to every cell; at most one is set
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_cmd_t;

    typedef struct packed {
        logic [MAXMSG_W-1:0] max_messages;
        logic [LEN_W-1:0]    max_msg_size;
        logic                nonblocking;
    } cfg_t;

endpackage

// ===== src/pmq_cell.sv =====
// One slot of the sorted shift chain: holds an entry, shifts or loads on command.
`timescale 1ns / 1ps

module pmq_cell (
    input  logic              aclk,
    input  pmq_pkg::cell_cmd_t cmd,
    input  logic              occupied,     // slot index < held count
    input  pmq_pkg::entry_t   new_entry,    // entry being sent
    input  logic              left_keep,    // neighbor toward head keeps its entry
    input  pmq_pkg::entry_t   left_entry,
    input  pmq_pkg::entry_t   right_entry,
    output pmq_pkg::entry_t   entry,
    output logic              keep
);

    pmq_pkg::entry_t entry_reg;
    pmq_pkg::entry_t entry_next;

    // ties stay ahead of the new entry, so equal priorities leave in order
    assign keep  = occupied && (entry_reg.prio >= new_entry.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.insert) begin
            if (!keep) begin
                entry_next = left_keep ? new_entry : left_entry;
            end
        end else if (cmd.remove) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== src/pmq_ctrl.sv =====
// Status decision and held-count register of the priority message queue.
`timescale 1ns / 1ps

module pmq_ctrl #(
    parameter int QUEUE_DEPTH = pmq_pkg::QUEUE_DEPTH_DEF,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  logic                       opcode,
    input  logic [pmq_pkg::LEN_W-1:0]  msg_length,
    input  logic [pmq_pkg::LEN_W-1:0]  buffer_length,
    input  pmq_pkg::cfg_t              cfg,
    output pmq_pkg::cell_cmd_t         cmd,
    output pmq_pkg::status_t           status,
    output logic [CNT_W-1:0]           count,
    output logic [CNT_W-1:0]           count_after
);

    localparam int CMP_W = (CNT_W > pmq_pkg::MAXMSG_W) ? CNT_W : pmq_pkg::MAXMSG_W;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             full;
    logic             empty;
    pmq_pkg::status_t busy;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH)) ||
                   (CMP_W'(count_reg) >= CMP_W'(cfg.max_messages));
    assign empty = (count_reg == '0);
    assign busy  = cfg.nonblocking ? pmq_pkg::ST_AGAIN : pmq_pkg::ST_BLOCK;

    always_comb begin
        status     = pmq_pkg::ST_OK;
        cmd        = '0;
        count_next = count_reg;
        case (opcode)
            pmq_pkg::OP_SEND: begin
                if (msg_length > cfg.max_msg_size) begin
                    status = pmq_pkg::ST_SIZE;
                end else if (full) begin
                    status = busy;
                end else begin
                    cmd.insert = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            pmq_pkg::OP_RECV: begin
                if (buffer_length < cfg.max_msg_size) begin
                    status = pmq_pkg::ST_SIZE;
                end else if (empty) begin
                    status = busy;
                end else begin
                    cmd.remove = accept;
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
                status = pmq_pkg::ST_OK;
            end
        endcase
    end

    assign count       = count_reg;
    assign count_after = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/priority_message_queue.sv =====
// Top level of the priority message queue: config port, cell chain, result register.
// A result appears on the m_ side in the cycle after its item is accepted.
// Throughput: 1 item per cycle while s_tready is high; every cell updates in parallel in that cycle.
// s_tready drops only while a registered result is held by m_tready low.
// Reset (aresetn, synchronous, active low) empties the queue, restores the
// registers to their defaults and drops m_tvalid; slot contents are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module priority_message_queue #(
    parameter int QUEUE_DEPTH = pmq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // priority_req[14:0], payload[46:15],
                                   // msg_length[62:47], buffer_length[78:63], 0
    input  logic        s_tuser,   // opcode

    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // out_payload[31:0], out_length[47:32],
                                   // out_priority[62:48], queue_count[67:63], 0
    output logic [1:0]  m_tuser,   // status

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > pmq_pkg::QCOUNT_W) ? CNT_W : pmq_pkg::QCOUNT_W;

    // ---------------- configuration registers ----------------
    pmq_pkg::cfg_t cfg_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_messages <= pmq_pkg::MAX_MESSAGES_RST;
            cfg_reg.max_msg_size <= pmq_pkg::MAX_MSG_SIZE_RST;
            cfg_reg.nonblocking  <= pmq_pkg::NONBLOCKING_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                pmq_pkg::REG_MAX_MESSAGES:
                    cfg_reg.max_messages <= pwdata[pmq_pkg::MAXMSG_W-1:0];
                pmq_pkg::REG_MAX_MSG_SIZE:
                    cfg_reg.max_msg_size <= pwdata[pmq_pkg::LEN_W-1:0];
                pmq_pkg::REG_NONBLOCKING:
                    cfg_reg.nonblocking  <= pwdata[0];
                default: ;  // unmapped address, write ignored
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pmq_pkg::REG_MAX_MESSAGES: prdata = 32'(cfg_reg.max_messages);
            pmq_pkg::REG_MAX_MSG_SIZE: prdata = 32'(cfg_reg.max_msg_size);
            pmq_pkg::REG_NONBLOCKING:  prdata = 32'(cfg_reg.nonblocking);
            default:                   prdata = '0;
        endcase
    end

    // ---------------- input unpacking ----------------
    logic                        s_accept;
    logic                        opcode;
    pmq_pkg::entry_t             new_entry;
    logic [pmq_pkg::LEN_W-1:0]   buffer_length;

    assign opcode            = s_tuser;
    assign new_entry.prio    = s_tdata[14:0];
    assign new_entry.payload = s_tdata[46:15];
    assign new_entry.length  = s_tdata[62:47];
    assign buffer_length     = s_tdata[78:63];

    // output register frees whenever its result is taken
    logic m_valid_reg;
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // ---------------- control ----------------
    pmq_pkg::cell_cmd_t cmd;
    pmq_pkg::status_t   status;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   count_after;

    pmq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (s_accept),
        .opcode        (opcode),
        .msg_length    (new_entry.length),
        .buffer_length (buffer_length),
        .cfg           (cfg_reg),
        .cmd           (cmd),
        .status        (status),
        .count         (count),
        .count_after   (count_after)
    );

    // ---------------- cell chain, slot 0 is the head ----------------
    // On send each cell compares its own priority with the new one; the keep
    // flags form a prefix, the first non-keeping cell loads the new entry and
    // the cells behind it take their left neighbor's entry. On receive every
    // cell takes its right neighbor's entry, and the tail cell keeps its own.
    pmq_pkg::entry_t cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_keep;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        pmq_pkg::entry_t left_entry;
        pmq_pkg::entry_t right_entry;
        logic            left_keep;
        logic            occupied;

        if (i == 0) begin : g_head
            assign left_entry = new_entry;
            assign left_keep  = 1'b1;
        end else begin : g_body
            assign left_entry = cell_entry[i-1];
            assign left_keep  = cell_keep[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign right_entry = cell_entry[i];
        end else begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        assign occupied = (CNT_W'(i) < count);

        pmq_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .occupied    (occupied),
            .new_entry   (new_entry),
            .left_keep   (left_keep),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

    // ---------------- result register ----------------
    pmq_pkg::entry_t  res_entry;
    logic [CMP_W-1:0] count_ext;
    logic [71:0]      m_data_reg;
    logic [1:0]       m_user_reg;

    // returned fields are zero unless a receive succeeds
    assign res_entry = (opcode == pmq_pkg::OP_RECV && status == pmq_pkg::ST_OK)
                       ? cell_entry[0] : '0;
    assign count_ext = CMP_W'(count_after);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= {4'd0, count_ext[pmq_pkg::QCOUNT_W-1:0], res_entry.prio,
                           res_entry.length, res_entry.payload};
            m_user_reg <= status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // ---------------- assertions ----------------
    `PMQ_ASSERT(a_count_bound, count <= CNT_W'(QUEUE_DEPTH))
    `PMQ_ASSERT_NXT(a_count_hold, !s_accept, $stable(count))
    `PMQ_ASSERT_IMP(a_head_sorted, count >= CNT_W'(2), cell_entry[0].prio >= cell_entry[1].prio)
    `PMQ_ASSERT_IMP(a_fail_zero, m_tvalid && m_tuser != pmq_pkg::ST_OK, m_tdata[62:0] == 63'd0)

endmodule

// ===== tb/priority_message_queue_tb.sv =====
// Self-checking stream testbench for the priority message queue: directed and random items.
`timescale 1ns / 1ps

module priority_message_queue_tb;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 150;

    typedef logic [pmq_pkg::PRIO_W-1:0]    prio_t;
    typedef logic [pmq_pkg::PAYLOAD_W-1:0] word_t;
    typedef logic [pmq_pkg::LEN_W-1:0]     len_t;

    typedef struct {
        logic  op;
        prio_t prio;
        word_t payload;
        len_t  msg_len;
        len_t  buf_len;
    } msg_item_t;

    typedef struct {
        pmq_pkg::status_t              status;
        word_t                         payload;
        len_t                          length;
        prio_t                         prio;
        logic [pmq_pkg::QCOUNT_W-1:0]  count;
    } msg_result_t;

    // DUT ports
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow configuration and queue contents
    logic [pmq_pkg::MAXMSG_W-1:0] cfg_max_messages = pmq_pkg::MAX_MESSAGES_RST;
    len_t                         cfg_max_msg_size = pmq_pkg::MAX_MSG_SIZE_RST;
    logic                         cfg_nonblocking  = pmq_pkg::NONBLOCKING_RST;
    pmq_pkg::entry_t              held_msgs [DEPTH];
    int                           held_count = 0;

    msg_item_t   pending_items[$];
    msg_result_t expected_results[$];
    msg_item_t   cur_item;

    int fail_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int rdy_mode = 0;
    int rdy_left = 0;

    priority_message_queue u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Apply one item to the queue image and return what the block must answer.
    function automatic msg_result_t queue_step(input msg_item_t it);
        msg_result_t r;
        int          cap;
        int          pos;
        int          i;
        r.status  = pmq_pkg::ST_OK;
        r.payload = '0;
        r.length  = '0;
        r.prio    = '0;
        cap = (int'(cfg_max_messages) < DEPTH) ? int'(cfg_max_messages) : DEPTH;
        if (it.op == pmq_pkg::OP_SEND) begin
            if (it.msg_len > cfg_max_msg_size) begin
                r.status = pmq_pkg::ST_SIZE;
            end else if (held_count >= cap) begin
                r.status = cfg_nonblocking ? pmq_pkg::ST_AGAIN : pmq_pkg::ST_BLOCK;
            end else begin
                // behind every entry of equal or higher priority
                pos = 0;
                while (pos < held_count && held_msgs[pos].prio >= it.prio) pos++;
                for (i = held_count; i > pos; i--) held_msgs[i] = held_msgs[i-1];
                held_msgs[pos].prio    = it.prio;
                held_msgs[pos].payload = it.payload;
                held_msgs[pos].length  = it.msg_len;
                held_count++;
            end
        end else begin
            if (it.buf_len < cfg_max_msg_size) begin
                r.status = pmq_pkg::ST_SIZE;
            end else if (held_count == 0) begin
                r.status = cfg_nonblocking ? pmq_pkg::ST_AGAIN : pmq_pkg::ST_BLOCK;
            end else begin
                r.payload = held_msgs[0].payload;
                r.length  = held_msgs[0].length;
                r.prio    = held_msgs[0].prio;
                for (i = 1; i < held_count; i++) held_msgs[i-1] = held_msgs[i];
                held_count--;
            end
        end
        r.count = held_count[pmq_pkg::QCOUNT_W-1:0];
        return r;
    endfunction

    function automatic msg_item_t send_item(input prio_t prio, input word_t payload,
                                            input len_t len);
        msg_item_t it;
        it.op      = pmq_pkg::OP_SEND;
        it.prio    = prio;
        it.payload = payload;
        it.msg_len = len;
        it.buf_len = len_t'($urandom);
        return it;
    endfunction

    function automatic msg_item_t recv_item(input len_t buf_len);
        msg_item_t it;
        it.op      = pmq_pkg::OP_RECV;
        it.prio    = prio_t'($urandom);
        it.payload = $urandom;
        it.msg_len = len_t'($urandom);
        it.buf_len = buf_len;
        return it;
    endfunction

    // Mostly well-formed items; about one in ten breaks the size rule.
    function automatic msg_item_t random_item(input int send_pct);
        msg_item_t it;
        int        maxsz;
        maxsz = int'(cfg_max_msg_size);
        it.op = ($urandom_range(0, 99) < send_pct) ? pmq_pkg::OP_SEND : pmq_pkg::OP_RECV;
        case ($urandom_range(0, 3))
            0: it.prio = prio_t'($urandom_range(0, 3));          // lots of ties
            1: it.prio = $urandom_range(0, 1) ? 15'h7fff : 15'h0000;
            default: it.prio = prio_t'($urandom);
        endcase
        it.payload = $urandom;
        it.msg_len = len_t'($urandom);
        it.buf_len = len_t'($urandom);
        if (it.op == pmq_pkg::OP_SEND) begin
            if ($urandom_range(0, 9) != 0 || maxsz == 65535) begin
                it.msg_len = len_t'($urandom_range(0, maxsz));
            end else begin
                it.msg_len = len_t'($urandom_range(maxsz + 1, 65535));
            end
        end else begin
            if ($urandom_range(0, 9) != 0 || maxsz == 0) begin
                it.buf_len = len_t'($urandom_range(maxsz, 65535));
            end else begin
                it.buf_len = len_t'($urandom_range(0, maxsz - 1));
            end
        end
        return it;
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            pmq_pkg::REG_MAX_MESSAGES: cfg_max_messages = value[pmq_pkg::MAXMSG_W-1:0];
            pmq_pkg::REG_MAX_MSG_SIZE: cfg_max_msg_size = value[pmq_pkg::LEN_W-1:0];
            pmq_pkg::REG_NONBLOCKING:  cfg_nonblocking  = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int mm, input int sz, input int nb);
        reg_write(pmq_pkg::REG_MAX_MESSAGES, mm);
        reg_write(pmq_pkg::REG_MAX_MSG_SIZE, sz);
        reg_write(pmq_pkg::REG_NONBLOCKING, nb);
    endtask

    // Sampled at the falling edge so the clocked blocks have settled.
    task automatic wait_idle();
        @(negedge aclk);
        while (pending_items.size() != 0 || expected_results.size() != 0 || s_tvalid)
            @(negedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Item driver: bursts of random length, random gaps between them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(queue_step(cur_item));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_item.op;
                    s_tdata  <= {1'b0, cur_item.buf_len, cur_item.msg_len,
                                 cur_item.payload, cur_item.prio};
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall pattern.
    always @(posedge aclk) begin
        msg_result_t exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d data %0h",
                             $time, m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("status", exp_r.status, m_tuser);
                    check_field("out_payload", exp_r.payload, m_tdata[31:0]);
                    check_field("out_length", exp_r.length, m_tdata[47:32]);
                    check_field("out_priority", exp_r.prio, m_tdata[62:48]);
                    check_field("queue_count", exp_r.count, m_tdata[67:63]);
                end
            end
            if (rdy_left == 0) begin
                rdy_mode = $urandom_range(0, 3);
                rdy_left = $urandom_range(4, 40);
            end else begin
                rdy_left--;
            end
            case (rdy_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rdy_left > 12);   // long stall at the end
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("priority_message_queue test failed");
            $finish;
        end
    end

    initial begin
        int ph;
        int n;
        int send_pct;
        int mm;
        int sz;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset defaults: empty receive, oversize send, size extremes, FIFO tie
        pending_items.push_back(recv_item(16'hffff));
        pending_items.push_back(send_item(15'd9, 32'h1234_5678, 16'd8193));
        pending_items.push_back(send_item(15'd0, 32'h0000_0000, 16'd8192));
        pending_items.push_back(send_item(15'h7fff, 32'hffff_ffff, 16'd0));
        pending_items.push_back(send_item(15'd5, 32'haaaa_5555, 16'd100));
        pending_items.push_back(send_item(15'd5, 32'h5555_aaaa, 16'd200));
        pending_items.push_back(recv_item(16'd8191));   // too small while holding
        pending_items.push_back(recv_item(16'd8192));
        pending_items.push_back(recv_item(16'hffff));
        pending_items.push_back(recv_item(16'hffff));
        wait_idle();

        // small capacity, nonblocking: full send reports again
        set_config(2, 8192, 1);
        pending_items.push_back(send_item(15'd1, 32'h0000_0001, 16'd1));
        pending_items.push_back(send_item(15'd3, 32'h0000_0002, 16'd2));
        wait_idle();

        // capacity lowered below the held count
        set_config(1, 8192, 1);
        pending_items.push_back(send_item(15'd7, 32'h0000_0003, 16'd3));
        pending_items.push_back(recv_item(16'hffff));
        pending_items.push_back(send_item(15'd7, 32'h0000_0004, 16'd4));
        pending_items.push_back(recv_item(16'hffff));
        pending_items.push_back(recv_item(16'hffff));   // empty, again
        pending_items.push_back(send_item(15'd2, 32'hdead_beef, 16'd5));
        wait_idle();

        // zero capacity and zero size limit, blocking mode
        set_config(0, 0, 0);
        pending_items.push_back(send_item(15'd4, 32'h0000_0006, 16'd0));
        pending_items.push_back(recv_item(16'd0));
        pending_items.push_back(recv_item(16'd0));      // empty, would block
        wait_idle();

        // capacity field above the depth, largest size limit
        set_config(31, 65535, 0);
        pending_items.push_back(send_item(15'h4000, 32'h8000_0001, 16'hffff));
        pending_items.push_back(recv_item(16'hfffe));
        pending_items.push_back(recv_item(16'hffff));
        wait_idle();

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0) begin
                mm = 16;
                sz = 65535;
            end else if (ph == 1) begin
                mm = 1;
                sz = 0;
            end else begin
                case ($urandom_range(0, 5))
                    0: mm = 0;
                    1: mm = 31;
                    2: mm = 16;
                    default: mm = $urandom_range(1, 16);
                endcase
                case ($urandom_range(0, 4))
                    0: sz = 0;
                    1: sz = 65535;
                    2: sz = $urandom_range(0, 255);
                    default: sz = $urandom_range(0, 65535);
                endcase
            end
            set_config(mm, sz, (ph == 0) ? 0 : (ph == 1) ? 1 : $urandom_range(0, 1));
            // alternate fill and drain tides so full and empty are both reached
            send_pct = 70;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 25 == 24) send_pct = 100 - send_pct;
                pending_items.push_back(random_item(send_pct));
            end
            wait_idle();
        end

        repeat (4) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("priority_message_queue test passed");
        end else begin
            $display("priority_message_queue test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/pmq_pkg.sv
src/pmq_cell.sv
src/pmq_ctrl.sv
src/priority_message_queue.sv
tb/priority_message_queue_tb.sv
